@@ rtl/krt_pkg.sv @@
// Shared types and codes for the keyed record table.
package krt_pkg;

    localparam int NAME_W = 200;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_SEARCH = 2'd1,
        MODE_UPDATE = 2'd2,
        MODE_LIST   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_DUP      = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_LIST     = 3'd4,
        ST_EMPTY    = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FETCH,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] part_key;
        logic [63:0]        name_word_0;
        logic [63:0]        name_word_1;
        logic [63:0]        name_word_2;
        logic [7:0]         name_word_3;
        logic signed [31:0] amount;
    } t_req;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] out_key;
        logic [63:0]        out_name_0;
        logic [63:0]        out_name_1;
        logic [63:0]        out_name_2;
        logic [7:0]         out_name_3;
        logic signed [31:0] out_quantity;
        logic               last;
    } t_rsp;

    typedef struct packed {
        logic    load;
        logic    rd_en;
        logic    fetch;
        logic    cmp;
        logic    scan_clr;
        logic    round_clr;
        logic    take;
        logic    wr_ins;
        logic    wr_qty;
        logic    emit;
        t_status code;
        logic    last;
    } t_cmd;

    typedef struct packed {
        logic hit;
    } t_sts;

endpackage

@@ rtl/keyed_record_table.sv @@
// Top level of the keyed record table: controller plus record datapath.
//
// Usage: drive a request on i_req and raise start; the request is taken on a
// clock edge where start is high and busy is low. Modes: insert, search,
// update quantity (saturating add) and list in ascending signed key order.
// Results appear on o_rsp for exactly one cycle with o_strobe high; the
// receiver cannot hold them off, so capture every strobe. o_rsp.last marks
// the final result of a request.
// Every lookup scans the stored keys one per cycle through the key memory
// read port, comparing each key once it is registered from the memory. An
// insert with no duplicate writes its new record in the emit step; a search
// or update that hits reads the matched record again in a fetch step before
// emitting, and a miss goes straight to emit. A full insert or an empty list
// skips the scan and goes straight to emit. List repeats a full scan and a
// fetch per reported record; the single memory read port sets this order.
// Reset clears the record count and the control state; record memories are
// not cleared, and only entries below the count are ever read.
// A new request may be started in the cycle its predecessor's last result
// is on the outputs.
module keyed_record_table #(
    parameter int MAX_ENTRIES = 64,
    parameter int NAME_BYTES  = 25
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  krt_pkg::t_req i_req,
    output logic          busy,
    output krt_pkg::t_rsp o_rsp,
    output logic          o_strobe
);

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    krt_pkg::t_cmd cmd;
    krt_pkg::t_sts sts;
    logic [IW-1:0] scan_addr;
    logic [IW-1:0] cmp_idx;
    logic [IW-1:0] wr_addr;

    // Sequence the scan, fetch and emit steps.
    krt_ctrl #(
        .MAX_ENTRIES(MAX_ENTRIES),
        .IW         (IW),
        .CW         (CW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_mode     (i_req.mode),
        .i_sts      (sts),
        .busy       (busy),
        .o_cmd      (cmd),
        .o_scan_addr(scan_addr),
        .o_cmp_idx  (cmp_idx),
        .o_wr_addr  (wr_addr)
    );

    // Hold the records, compare keys and drive the result register.
    krt_datapath #(
        .MAX_ENTRIES(MAX_ENTRIES),
        .NAME_BYTES (NAME_BYTES),
        .IW         (IW)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_req      (i_req),
        .i_scan_addr(scan_addr),
        .i_cmp_idx  (cmp_idx),
        .i_wr_addr  (wr_addr),
        .o_sts      (sts),
        .o_rsp      (o_rsp),
        .o_strobe   (o_strobe)
    );

endmodule

@@ rtl/krt_datapath.sv @@
// Record stores, key compare, ordering search and result register.
module krt_datapath #(
    parameter int MAX_ENTRIES = 64,
    parameter int NAME_BYTES  = 25,
    parameter int IW          = 6
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  krt_pkg::t_cmd   i_cmd,
    input  krt_pkg::t_req   i_req,
    input  logic [IW-1:0]   i_scan_addr,
    input  logic [IW-1:0]   i_cmp_idx,
    input  logic [IW-1:0]   i_wr_addr,
    output krt_pkg::t_sts   o_sts,
    output krt_pkg::t_rsp   o_rsp,
    output logic            o_strobe
);

    logic signed [31:0]        key_mem  [MAX_ENTRIES];
    logic signed [31:0]        qty_mem  [MAX_ENTRIES];
    logic [krt_pkg::NAME_W-1:0] name_mem [MAX_ENTRIES];

    logic [1:0]                 r_mode;
    logic signed [31:0]         r_key;
    logic signed [31:0]         r_amount;
    logic [krt_pkg::NAME_W-1:0] r_name;
    logic signed [31:0]         r_key_q;
    logic signed [31:0]         r_qty_q;
    logic [krt_pkg::NAME_W-1:0] r_name_q;
    logic                       r_hit;
    logic                       r_bv;
    logic                       r_first;
    logic signed [31:0]         r_best;
    logic signed [31:0]         r_prev;
    logic [IW-1:0]              r_pick;
    krt_pkg::t_rsp              r_rsp;
    logic                       r_strobe;

    logic [krt_pkg::NAME_W-1:0] name_in;
    logic [IW-1:0]              rd_addr;
    logic [IW-1:0]              qty_addr;
    logic signed [31:0]         qty_wdata;
    logic                       cand;
    logic signed [32:0]         sum;
    logic signed [31:0]         sat;
    krt_pkg::t_rsp              n_rsp;

    always_comb begin
        name_in = {i_req.name_word_3, i_req.name_word_2, i_req.name_word_1,
                   i_req.name_word_0};
        for (int b = 0; b < krt_pkg::NAME_W / 8; b++) begin
            if (b >= NAME_BYTES) begin
                name_in[b*8 +: 8] = 8'd0;
            end
        end
    end

    assign rd_addr = i_cmd.fetch ? r_pick : i_scan_addr;

    // One quantity write port: the update write-back or the new record.
    assign qty_addr  = i_cmd.wr_qty ? r_pick : i_wr_addr;
    assign qty_wdata = i_cmd.wr_qty ? sat : r_amount;

    // Next key in ascending order: above the last one reported, below the best so far.
    assign cand = (r_first || (r_key_q > r_prev)) && (!r_bv || (r_key_q < r_best));

    assign sum = {r_qty_q[31], r_qty_q} + {r_amount[31], r_amount};
    assign sat = (sum[32] != sum[31]) ? (sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff)
                                      : sum[31:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en || i_cmd.fetch) begin
            r_key_q  <= key_mem[rd_addr];
            r_qty_q  <= qty_mem[rd_addr];
            r_name_q <= name_mem[rd_addr];
        end
        if (i_cmd.wr_ins) begin
            key_mem[i_wr_addr]  <= r_key;
            name_mem[i_wr_addr] <= r_name;
        end
        if (i_cmd.wr_ins || i_cmd.wr_qty) begin
            qty_mem[qty_addr] <= qty_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode   <= i_req.mode;
            r_key    <= i_req.part_key;
            r_amount <= i_req.amount;
            r_name   <= name_in;
            r_first  <= 1'b1;
        end else if (i_cmd.take) begin
            r_first <= 1'b0;
            r_prev  <= r_best;
        end
        if (i_cmd.scan_clr) begin
            r_hit <= 1'b0;
            r_bv  <= 1'b0;
        end else if (i_cmd.round_clr) begin
            r_bv <= 1'b0;
        end else if (i_cmd.cmp) begin
            if (r_mode == krt_pkg::MODE_LIST) begin
                if (cand) begin
                    r_bv   <= 1'b1;
                    r_best <= r_key_q;
                    r_pick <= i_cmp_idx;
                end
            end else if (r_key_q == r_key) begin
                r_hit  <= 1'b1;
                r_pick <= i_cmp_idx;
            end
        end
    end

    always_comb begin
        n_rsp        = '0;
        n_rsp.status = i_cmd.code;
        n_rsp.last   = i_cmd.last;
        unique case (i_cmd.code)
            krt_pkg::ST_OK: begin
                n_rsp.out_key = r_key;
                if (r_mode == krt_pkg::MODE_INSERT) begin
                    {n_rsp.out_name_3, n_rsp.out_name_2, n_rsp.out_name_1,
                     n_rsp.out_name_0} = r_name;
                    n_rsp.out_quantity = r_amount;
                end else begin
                    {n_rsp.out_name_3, n_rsp.out_name_2, n_rsp.out_name_1,
                     n_rsp.out_name_0} = r_name_q;
                    n_rsp.out_quantity = (r_mode == krt_pkg::MODE_UPDATE) ? sat : r_qty_q;
                end
            end
            krt_pkg::ST_LIST: begin
                n_rsp.out_key = r_key_q;
                {n_rsp.out_name_3, n_rsp.out_name_2, n_rsp.out_name_1,
                 n_rsp.out_name_0} = r_name_q;
                n_rsp.out_quantity = r_qty_q;
            end
            krt_pkg::ST_FULL, krt_pkg::ST_DUP, krt_pkg::ST_NOTFOUND: begin
                n_rsp.out_key = r_key;
            end
            default: begin
                n_rsp.out_key = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
        end
        if (i_cmd.emit) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_sts.hit = r_hit;
    assign o_rsp     = r_rsp;
    assign o_strobe  = r_strobe;

endmodule

@@ rtl/krt_ctrl.sv @@
// Sequencer: entry count, scan counter and operation state machine.
module krt_ctrl #(
    parameter int MAX_ENTRIES = 64,
    parameter int IW          = 6,
    parameter int CW          = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  logic [1:0]    i_mode,
    input  krt_pkg::t_sts i_sts,
    output logic          busy,
    output krt_pkg::t_cmd o_cmd,
    output logic [IW-1:0] o_scan_addr,
    output logic [IW-1:0] o_cmp_idx,
    output logic [IW-1:0] o_wr_addr
);

    krt_pkg::t_state  r_state, n_state;
    krt_pkg::t_status r_code, n_code;
    logic [1:0]       r_mode, n_mode;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_i, n_i;
    logic [CW-1:0]    r_rank, n_rank;
    logic             r_pend, n_pend;
    logic [IW-1:0]    r_pidx, n_pidx;
    logic             issue;

    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= krt_pkg::S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
        r_code <= n_code;
        r_mode <= n_mode;
        r_i    <= n_i;
        r_rank <= n_rank;
        r_pidx <= n_pidx;
    end

    assign issue = (r_state == krt_pkg::S_SCAN) && (r_i < r_count);

    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        n_mode  = r_mode;
        n_count = r_count;
        n_i     = r_i;
        n_rank  = r_rank;
        n_pend  = issue;
        n_pidx  = r_i[IW-1:0];
        o_cmd   = '0;
        o_cmd.code = r_code;
        o_cmd.last = 1'b1;
        unique case (r_state)
            krt_pkg::S_IDLE: begin
                if (start) begin
                    o_cmd.load     = 1'b1;
                    o_cmd.scan_clr = 1'b1;
                    n_mode = i_mode;
                    n_i    = '0;
                    n_rank = '0;
                    if (i_mode == krt_pkg::MODE_INSERT && r_count >= MAX_CNT) begin
                        n_code  = krt_pkg::ST_FULL;
                        n_state = krt_pkg::S_EMIT;
                    end else if (i_mode == krt_pkg::MODE_LIST && r_count == '0) begin
                        n_code  = krt_pkg::ST_EMPTY;
                        n_state = krt_pkg::S_EMIT;
                    end else begin
                        n_state = krt_pkg::S_SCAN;
                    end
                end
            end
            krt_pkg::S_SCAN: begin
                o_cmd.rd_en = issue;
                o_cmd.cmp   = r_pend;
                if (issue) begin
                    n_i = r_i + 1'b1;
                end
                if (!issue && !r_pend) begin
                    priority if (r_mode == krt_pkg::MODE_LIST) begin
                        n_code  = krt_pkg::ST_LIST;
                        n_state = krt_pkg::S_FETCH;
                    end else if (r_mode == krt_pkg::MODE_INSERT) begin
                        n_code  = i_sts.hit ? krt_pkg::ST_DUP : krt_pkg::ST_OK;
                        n_state = krt_pkg::S_EMIT;
                    end else if (i_sts.hit) begin
                        n_code  = krt_pkg::ST_OK;
                        n_state = krt_pkg::S_FETCH;
                    end else begin
                        n_code  = krt_pkg::ST_NOTFOUND;
                        n_state = krt_pkg::S_EMIT;
                    end
                end
            end
            krt_pkg::S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = krt_pkg::S_EMIT;
            end
            krt_pkg::S_EMIT: begin
                o_cmd.emit = 1'b1;
                n_state    = krt_pkg::S_IDLE;
                if (r_code == krt_pkg::ST_OK && r_mode == krt_pkg::MODE_INSERT) begin
                    o_cmd.wr_ins = 1'b1;
                    n_count      = r_count + 1'b1;
                end
                if (r_code == krt_pkg::ST_OK && r_mode == krt_pkg::MODE_UPDATE) begin
                    o_cmd.wr_qty = 1'b1;
                end
                if (r_code == krt_pkg::ST_LIST) begin
                    o_cmd.last = (r_rank + 1'b1 == r_count);
                    o_cmd.take = 1'b1;
                    n_rank     = r_rank + 1'b1;
                    if (r_rank + 1'b1 != r_count) begin
                        o_cmd.round_clr = 1'b1;
                        n_i     = '0;
                        n_state = krt_pkg::S_SCAN;
                    end
                end
            end
            default: begin
                n_state = krt_pkg::S_IDLE;
            end
        endcase
    end

    assign busy        = (r_state != krt_pkg::S_IDLE);
    assign o_scan_addr = r_i[IW-1:0];
    assign o_cmp_idx   = r_pidx;
    assign o_wr_addr   = r_count[IW-1:0];

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the keyed record table.
module tb;

    localparam int TABLE_DEPTH = 64;
    localparam int STALL_LIMIT = 20000;

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    krt_pkg::t_req i_req;
    logic          busy;
    krt_pkg::t_rsp o_rsp;
    logic          o_strobe;

    keyed_record_table uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_rsp   (o_rsp),
        .o_strobe(o_strobe)
    );

    // Shadow copy of the record table.
    logic signed [31:0] shadow_key [TABLE_DEPTH];
    logic [199:0]       shadow_name [TABLE_DEPTH];
    logic signed [31:0] shadow_qty [TABLE_DEPTH];
    int                 shadow_count;

    krt_pkg::t_rsp pending_rsp[$];
    int            error_count;
    int            stall_cycles;
    bit            quiet_tail;

    // Directed table: request plus optional hand-typed result.
    typedef struct {
        krt_pkg::t_req req;
        bit            has_fixed;
        krt_pkg::t_rsp fixed;
    } t_row;

    t_row directed_rows[$];

    function automatic krt_pkg::t_rsp make_rsp(krt_pkg::t_status st, logic signed [31:0] k,
                                               logic [199:0] nm, logic signed [31:0] q,
                                               logic lst);
        krt_pkg::t_rsp r;
        r.status       = st;
        r.out_key      = k;
        r.out_name_0   = nm[63:0];
        r.out_name_1   = nm[127:64];
        r.out_name_2   = nm[191:128];
        r.out_name_3   = nm[199:192];
        r.out_quantity = q;
        r.last         = lst;
        return r;
    endfunction

    function automatic int find_record(logic signed [31:0] k);
        for (int i = 0; i < shadow_count; i++)
            if (shadow_key[i] == k) return i;
        return -1;
    endfunction

    // Apply one request to the shadow table and queue the results it causes.
    function automatic void predict_table(krt_pkg::t_req rq);
        int idx;
        int rank;
        longint sum;
        krt_pkg::t_rsp ordered[TABLE_DEPTH];
        case (krt_pkg::t_mode'(rq.mode))
            krt_pkg::MODE_INSERT: begin
                if (shadow_count >= TABLE_DEPTH) begin
                    pending_rsp.push_back(make_rsp(krt_pkg::ST_FULL, rq.part_key, '0, 0,
                                                   1'b1));
                end else if (find_record(rq.part_key) >= 0) begin
                    pending_rsp.push_back(make_rsp(krt_pkg::ST_DUP, rq.part_key, '0, 0,
                                                   1'b1));
                end else begin
                    shadow_key[shadow_count]  = rq.part_key;
                    shadow_name[shadow_count] = {rq.name_word_3, rq.name_word_2,
                                                 rq.name_word_1, rq.name_word_0};
                    shadow_qty[shadow_count]  = rq.amount;
                    pending_rsp.push_back(make_rsp(krt_pkg::ST_OK, rq.part_key,
                        shadow_name[shadow_count], rq.amount, 1'b1));
                    shadow_count++;
                end
            end
            krt_pkg::MODE_SEARCH, krt_pkg::MODE_UPDATE: begin
                idx = find_record(rq.part_key);
                if (idx < 0) begin
                    pending_rsp.push_back(make_rsp(krt_pkg::ST_NOTFOUND, rq.part_key, '0, 0,
                                                   1'b1));
                end else begin
                    if (krt_pkg::t_mode'(rq.mode) == krt_pkg::MODE_UPDATE) begin
                        // Saturate the signed sum at the 32-bit limits.
                        sum = longint'(shadow_qty[idx]) + longint'(rq.amount);
                        if (sum > 64'sd2147483647) sum = 64'sd2147483647;
                        if (sum < -64'sd2147483648) sum = -64'sd2147483648;
                        shadow_qty[idx] = sum[31:0];
                    end
                    pending_rsp.push_back(make_rsp(krt_pkg::ST_OK, rq.part_key,
                                                   shadow_name[idx], shadow_qty[idx], 1'b1));
                end
            end
            default: begin
                if (shadow_count == 0) begin
                    pending_rsp.push_back(make_rsp(krt_pkg::ST_EMPTY, 0, '0, 0, 1'b1));
                end else begin
                    for (int i = 0; i < shadow_count; i++) begin
                        rank = 0;
                        for (int j = 0; j < shadow_count; j++)
                            if (shadow_key[j] < shadow_key[i]) rank++;
                        ordered[rank] = make_rsp(krt_pkg::ST_LIST, shadow_key[i],
                                                 shadow_name[i], shadow_qty[i],
                                                 rank == shadow_count - 1);
                    end
                    for (int i = 0; i < shadow_count; i++) pending_rsp.push_back(ordered[i]);
                end
            end
        endcase
    endfunction

    function automatic krt_pkg::t_req make_req(krt_pkg::t_mode m, logic signed [31:0] k,
                                               logic [199:0] nm, logic signed [31:0] amt);
        krt_pkg::t_req r;
        r.mode        = m;
        r.part_key    = k;
        r.name_word_0 = nm[63:0];
        r.name_word_1 = nm[127:64];
        r.name_word_2 = nm[191:128];
        r.name_word_3 = nm[199:192];
        r.amount      = amt;
        return r;
    endfunction

    function automatic logic [199:0] random_name();
        logic [223:0] w;
        w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        return w[199:0];
    endfunction

    task automatic add_row(krt_pkg::t_req rq, bit fixed_ok, krt_pkg::t_rsp fx);
        t_row row;
        row.req       = rq;
        row.has_fixed = fixed_ok;
        row.fixed     = fx;
        directed_rows.push_back(row);
    endtask

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Compare each strobed result with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (pending_rsp.size() == 0) begin
                $display("%0t: unexpected result %p", $time, o_rsp);
                error_count++;
            end else if (o_rsp !== pending_rsp[0]) begin
                $display("%0t: mismatch expected %p actual %p", $time, pending_rsp[0], o_rsp);
                error_count++;
                void'(pending_rsp.pop_front());
            end else begin
                void'(pending_rsp.pop_front());
            end
        end
    end

    // Watchdog: count cycles in which no request is taken and no result is strobed.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles > STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Hold start high until the request is taken, then predict it.
    task automatic issue_request(krt_pkg::t_req rq);
        start <= 1'b1;
        i_req <= rq;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_table(rq);
    endtask

    // Drop start for a random burst unless in the quiet tail.
    task automatic maybe_idle();
        int gap;
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Random key drawn mostly from a small pool so hits and duplicates occur.
    function automatic logic signed [31:0] pick_key();
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return $urandom;
            default: return $signed($urandom_range(0, 40)) - 20;
        endcase
    endfunction

    initial begin
        logic [199:0]   ones;
        krt_pkg::t_req  rq;
        krt_pkg::t_rsp  none;
        krt_pkg::t_mode m;
        int             sel;
        error_count  = 0;
        stall_cycles = 0;
        shadow_count = 0;
        quiet_tail   = 1'b0;
        ones         = '1;
        none         = '0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_req        = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table, misses, extremes, saturation, duplicate.
        add_row(make_req(krt_pkg::MODE_LIST, 0, '0, 0), 1,
                make_rsp(krt_pkg::ST_EMPTY, 0, '0, 0, 1'b1));
        add_row(make_req(krt_pkg::MODE_SEARCH, 5, '0, 0), 1,
                make_rsp(krt_pkg::ST_NOTFOUND, 5, '0, 0, 1'b1));
        add_row(make_req(krt_pkg::MODE_UPDATE, -7, '0, 9), 1,
                make_rsp(krt_pkg::ST_NOTFOUND, -7, '0, 0, 1'b1));
        add_row(make_req(krt_pkg::MODE_INSERT, 32'sh7fff_ffff, ones, 32'sh7fff_ffff), 1,
                make_rsp(krt_pkg::ST_OK, 32'sh7fff_ffff, ones, 32'sh7fff_ffff, 1'b1));
        add_row(make_req(krt_pkg::MODE_INSERT, 32'sh8000_0000, '0, 32'sh8000_0000), 1,
                make_rsp(krt_pkg::ST_OK, 32'sh8000_0000, '0, 32'sh8000_0000, 1'b1));
        add_row(make_req(krt_pkg::MODE_INSERT, 32'sh7fff_ffff, '0, 1), 1,
                make_rsp(krt_pkg::ST_DUP, 32'sh7fff_ffff, '0, 0, 1'b1));
        add_row(make_req(krt_pkg::MODE_UPDATE, 32'sh7fff_ffff, '0, 32'sh7fff_ffff), 1,
                make_rsp(krt_pkg::ST_OK, 32'sh7fff_ffff, ones, 32'sh7fff_ffff, 1'b1));
        add_row(make_req(krt_pkg::MODE_UPDATE, 32'sh8000_0000, '0, 32'sh8000_0000), 1,
                make_rsp(krt_pkg::ST_OK, 32'sh8000_0000, '0, 32'sh8000_0000, 1'b1));
        add_row(make_req(krt_pkg::MODE_INSERT, 0, random_name(), -1), 0, none);
        add_row(make_req(krt_pkg::MODE_INSERT, -1, random_name(), 0), 0, none);
        add_row(make_req(krt_pkg::MODE_UPDATE, 0, '0, 32'sh8000_0000), 0, none);
        add_row(make_req(krt_pkg::MODE_UPDATE, 0, '0, -5), 0, none);
        add_row(make_req(krt_pkg::MODE_UPDATE, -1, '0, 32'sh7fff_ffff), 0, none);
        add_row(make_req(krt_pkg::MODE_SEARCH, -1, '0, 0), 0, none);
        add_row(make_req(krt_pkg::MODE_LIST, 0, '0, 0), 0, none);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].has_fixed) begin
                // Check the typed result agrees with the shadow table as well.
                rq = directed_rows[i].req;
                issue_request(rq);
                if (pending_rsp[$] !== directed_rows[i].fixed) begin
                    $display("%0t: mismatch expected %p actual %p", $time,
                             directed_rows[i].fixed, pending_rsp[$]);
                    error_count++;
                end
            end else begin
                issue_request(directed_rows[i].req);
            end
            maybe_idle();
        end
        drain_results();

        // Fill the table to capacity, then hit table full and list all records.
        while (shadow_count < TABLE_DEPTH) begin
            issue_request(make_req(krt_pkg::MODE_INSERT, $urandom, random_name(), $urandom));
            maybe_idle();
        end
        issue_request(make_req(krt_pkg::MODE_INSERT, 32'sh1234_5678, ones, 3));
        issue_request(make_req(krt_pkg::MODE_LIST, 0, '0, 0));
        issue_request(make_req(krt_pkg::MODE_SEARCH, shadow_key[TABLE_DEPTH - 1], '0, 0));
        drain_results();

        // Reset only once, so continue on the full table with lookups and updates,
        // mixing in inserts that exercise the full path.
        for (int n = 0; n < 200; n++) begin
            if (n > 170) quiet_tail = 1'b1;
            sel = $urandom_range(0, 19);
            if (sel == 0) m = krt_pkg::MODE_LIST;
            else if (sel < 5) m = krt_pkg::MODE_INSERT;
            else if (sel < 12) m = krt_pkg::MODE_SEARCH;
            else m = krt_pkg::MODE_UPDATE;
            if (m != krt_pkg::MODE_INSERT && $urandom_range(0, 2) != 0)
                rq = make_req(m, shadow_key[$urandom_range(0, shadow_count - 1)],
                              random_name(), $urandom);
            else
                rq = make_req(m, pick_key(), random_name(), $urandom);
            issue_request(rq);
            maybe_idle();
        end
        drain_results();

        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
